>>> rtl/fragment_reassembly_receiver_assert.svh
// ----------------------------------------------------------------------------
// fragment reassembly receiver assertion macros
// concurrent checks clocked on clk_i and held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_RECEIVER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF

`define FRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define FRR_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define FRR_ASSERT(name, prop, msg)

`define FRR_ASSERT_IMPLY(name, ante, cons, msg)

`endif

`endif

>>> rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// types and constants shared by the fragment reassembly receiver
// ----------------------------------------------------------------------------
`default_nettype none

package frr_pkg;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_POP  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_PEER     = 2'd0,
    CFG_PAIRED   = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_USE_RSSI = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_IGNORED   = 3'd1,
    EV_KEEPALIVE = 3'd2,
    EV_REALTIME  = 3'd3,
    EV_STORED    = 3'd4,
    EV_DELIVERED = 3'd5,
    EV_REJECTED  = 3'd6
  } ev_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_CLASSIFY,
    ST_COPY,
    ST_DRAIN,
    ST_EMIT
  } st_e;

  localparam logic [7:0]        TYPE_DATA      = 8'h03;
  localparam logic [7:0]        TYPE_REALTIME  = 8'h05;
  localparam logic [7:0]        TYPE_KEEPALIVE = 8'h06;
  localparam logic [7:0]        FRAME_LIMIT    = 8'd250;
  localparam logic [7:0]        CHAR_CR        = 8'h0D;
  localparam logic [7:0]        CHAR_LF        = 8'h0A;
  localparam logic signed [7:0] RSSI_NONE      = -8'sd100;
  localparam logic [15:0]       TIMEOUT_RESET  = 16'd3000;

  typedef struct packed {
    logic [1:0]        func;
    logic [7:0]        data_byte;
    logic              frame_start;
    logic              frame_end;
    logic [47:0]       src_mac;
    logic signed [7:0] link_rssi;
    logic              link_rssi_valid;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              out_valid;
    logic signed [7:0] filtered_rssi;
    logic [10:0]       bytes_waiting;
    logic              message_pending;
    logic [2:0]        frame_event;
  } out_item_t;

  typedef struct packed {
    logic [47:0] peer_address;
    logic        link_paired;
    logic [15:0] reassembly_timeout_ms;
    logic        use_link_rssi;
  } cfg_t;

  // request after the front end has sorted it
  typedef struct packed {
    func_e             kind;
    logic [7:0]        data_byte;
    logic              frame_start;
    logic              frame_end;
    logic              peer_match;
    logic              feed_rssi;
    logic signed [7:0] link_rssi;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/fragment_reassembly_receiver.sv
// ----------------------------------------------------------------------------
// fragment reassembly receiver
// Requests enter through a push/full queue port: a frame byte, a millisecond
// tick or a pop of one received byte. Every request yields exactly one
// result, read through an empty/pop queue port in request order.
// A front stage matches the frame source against the peer and queues up to
// two requests; the engine behind it runs one request at a time.
// A data fragment is copied from the staging ram into its slot, and a
// completed message from the slots into the ring, past empty slots. Each
// copy runs at one byte per cycle, using one port of the slot ram.
// Reset empties both queues and the ring, clears reassembly state and sets
// the averaged rssi to -100; config takes 3000 ms timeout and rssi use on.
// When the result side is not popped the engine holds its result and the
// input queue fills, then full stays high until results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_receiver #(
  parameter int RING_DEPTH  = 2048,
  parameter int FRAG_SLOTS  = 8,
  parameter int MAX_PAYLOAD = 246
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  input  wire frr_pkg::in_item_t   req_i,
  output logic                     full,
  output logic                     empty,
  input  wire logic                pop,
  output frr_pkg::out_item_t       rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [47:0]         cfg_wdata_i
);

  frr_pkg::cfg_t      cfg_q;
  frr_pkg::cmd_t      cmd;
  frr_pkg::out_item_t res;
  logic               cmd_empty, cmd_pop, res_full, res_push;
  logic [$bits(frr_pkg::out_item_t)-1:0] rsp_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peer_address          <= 48'd0;
      cfg_q.link_paired           <= 1'b0;
      cfg_q.reassembly_timeout_ms <= frr_pkg::TIMEOUT_RESET;
      cfg_q.use_link_rssi         <= 1'b1;
    end else if (cfg_we_i) begin
      case (frr_pkg::cfg_idx_e'(cfg_idx_i))
        frr_pkg::CFG_PEER:     cfg_q.peer_address          <= cfg_wdata_i;
        frr_pkg::CFG_PAIRED:   cfg_q.link_paired           <= cfg_wdata_i[0];
        frr_pkg::CFG_TIMEOUT:  cfg_q.reassembly_timeout_ms <= cfg_wdata_i[15:0];
        frr_pkg::CFG_USE_RSSI: cfg_q.use_link_rssi         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  frr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd),
    .cmd_empty_o(cmd_empty)
  );

  frr_engine #(
    .RING_DEPTH (RING_DEPTH),
    .FRAG_SLOTS (FRAG_SLOTS),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  frr_fifo #(
    .WIDTH($bits(frr_pkg::out_item_t))
  ) u_rsp_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (rsp_bits),
    .empty_o(empty)
  );

  assign rsp_o = frr_pkg::out_item_t'(rsp_bits);

endmodule

`default_nettype wire

>>> rtl/frr_ram.sv
// ----------------------------------------------------------------------------
// frr_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module frr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/frr_fifo.sv
// ----------------------------------------------------------------------------
// frr_fifo
// two entry queue that decouples producer and consumer
// ----------------------------------------------------------------------------
`default_nettype none

module frr_fifo #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/frr_front.sv
// ----------------------------------------------------------------------------
// frr_front
// takes requests, matches the source against the peer and queues them
// ----------------------------------------------------------------------------
`default_nettype none

module frr_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire frr_pkg::cfg_t    cfg_i,
  input  wire logic             push_i,
  input  wire frr_pkg::in_item_t req_i,
  output logic                  full_o,
  input  wire logic             cmd_pop_i,
  output frr_pkg::cmd_t         cmd_o,
  output logic                  cmd_empty_o
);

  frr_pkg::cmd_t cmd_in;
  logic [$bits(frr_pkg::cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.kind        = frr_pkg::func_e'(req_i.func);
    cmd_in.data_byte   = req_i.data_byte;
    cmd_in.frame_start = req_i.frame_start;
    cmd_in.frame_end   = req_i.frame_end;
    cmd_in.peer_match  = cfg_i.link_paired && (req_i.src_mac == cfg_i.peer_address);
    cmd_in.feed_rssi   = cmd_in.peer_match && cfg_i.use_link_rssi && req_i.link_rssi_valid;
    cmd_in.link_rssi   = req_i.link_rssi;
  end

  frr_fifo #(
    .WIDTH($bits(frr_pkg::cmd_t))
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_bits),
    .empty_o(cmd_empty_o)
  );

  assign cmd_o = frr_pkg::cmd_t'(cmd_bits);

endmodule

`default_nettype wire

>>> rtl/frr_engine.sv
// ----------------------------------------------------------------------------
// frr_engine
// frame assembly, classification, fragment commit and message delivery
// ----------------------------------------------------------------------------
`default_nettype none

`include "fragment_reassembly_receiver_assert.svh"

module frr_engine #(
  parameter int RING_DEPTH  = 2048,
  parameter int FRAG_SLOTS  = 8,
  parameter int MAX_PAYLOAD = 246
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire frr_pkg::cfg_t  cfg_i,
  input  wire logic           cmd_valid_i,
  input  wire frr_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output frr_pkg::out_item_t  res_o
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int SAW = $clog2(FRAG_SLOTS * 256);

  frr_pkg::st_e st_q, st_d;
  frr_pkg::ev_e ev_q, ev_d;

  logic [AW-1:0]     head_q, head_d, tail_q, tail_d, head_nxt, tail_nxt;
  logic [AW:0]       cnt_w;
  logic [7:0]        slot_len_q [8];
  logic [7:0]        got_q, got_d, total_mask;
  logic [3:0]        exp_q, exp_d;
  logic [7:0]        seq_q, seq_d;
  logic              pend_q, pend_d;
  logic [31:0]       tstart_q, tstart_d, time_q, time_d, age;
  logic signed [7:0] rssi_q, rssi_d, rssi_sample;
  logic              rssi_feed;
  logic [7:0]        fbc_q, fbc_d, fbc_base;
  logic [31:0]       hdr_q, hdr_d, hdr_base;
  logic              peer_q, peer_d;
  logic [7:0]        ob_q, ob_d;
  logic              ov_q, ov_d;
  logic [2:0]        idx_q, idx_d;
  logic [7:0]        plen_q, plen_d, rc_q, rc_d, wj_q, wj_d;
  logic              wv_q, wv_d;
  logic [3:0]        di_q, di_d;
  logic [7:0]        dj_q, dj_d, len_seen_q, len_seen_d, cur_len;
  logic              lf_q, lf_d;
  logic              clr_len, len_we, restart, frag_bad;
  logic [7:0]        h_type, h_seq, h_idx, h_total, h_plen;

  logic              put_en, ring_we, ring_re;
  logic [7:0]        put_data, ring_rdata;
  logic              stg_we, stg_re;
  logic [7:0]        stg_waddr, stg_raddr, stg_rdata;
  logic              slot_we, slot_re;
  logic [SAW-1:0]    slot_waddr, slot_raddr;
  logic [7:0]        slot_rdata;

  // running average weighting the new sample by one fifth, with a sign-magnitude reciprocal multiply
  function automatic logic signed [7:0] rssi_next(input logic signed [7:0] avg,
                                                  input logic signed [7:0] s);
    logic signed [10:0] sum;
    logic [9:0]         mag;
    logic [17:0]        prod;
    logic [7:0]         q;
    sum  = (11'(avg) <<< 2) + 11'(s);
    mag  = sum[10] ? 10'(-sum) : 10'(sum);
    prod = 18'(mag) * 18'd205;
    q    = 8'(prod >> 10);
    if (avg == frr_pkg::RSSI_NONE) begin
      rssi_next = s;
    end else begin
      rssi_next = sum[10] ? $signed(-q) : $signed(q);
    end
  endfunction

  assign head_nxt  = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt  = (tail_q == AW'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign cnt_w     = (head_q >= tail_q) ? (AW+1)'(head_q - tail_q)
                   : (AW+1)'(RING_DEPTH) - (AW+1)'(tail_q) + (AW+1)'(head_q);
  assign total_mask = 8'((9'd1 << exp_q) - 9'd1);
  assign fbc_base  = cmd_i.frame_start ? 8'd0 : fbc_q;
  assign hdr_base  = cmd_i.frame_start ? 32'd0 : hdr_q;
  assign stg_waddr = fbc_base - 8'd4;
  assign h_type    = hdr_q[7:0];
  assign h_seq     = hdr_q[15:8];
  assign h_idx     = hdr_q[23:16];
  assign h_total   = hdr_q[31:24];
  assign h_plen    = fbc_q - 8'd4;
  assign age       = time_q - tstart_q;
  assign cur_len   = slot_len_q[di_q[2:0]];
  assign frag_bad  = (h_total == 8'd0) || (h_total > 8'(FRAG_SLOTS)) || (h_idx >= h_total)
                   || (h_plen > 8'(MAX_PAYLOAD));
  assign restart   = !pend_q || (seq_q != h_seq) || (age > {16'd0, cfg_i.reassembly_timeout_ms});

  always_comb begin
    st_d = st_q;   ev_d = ev_q;   head_d = head_q; tail_d = tail_q;
    got_d = got_q; exp_d = exp_q; seq_d = seq_q;   pend_d = pend_q;
    tstart_d = tstart_q; time_d = time_q; rssi_d = rssi_q;
    fbc_d = fbc_q; hdr_d = hdr_q; peer_d = peer_q; ob_d = ob_q; ov_d = ov_q;
    idx_d = idx_q; plen_d = plen_q; rc_d = rc_q; wj_d = wj_q; wv_d = wv_q;
    di_d = di_q; dj_d = dj_q; len_seen_d = len_seen_q; lf_d = lf_q;
    cmd_pop_o = 1'b0; res_push_o = 1'b0;
    clr_len = 1'b0; len_we = 1'b0;
    rssi_feed = 1'b0; rssi_sample = cmd_i.link_rssi;
    put_en = 1'b0; put_data = 8'd0; ring_we = 1'b0; ring_re = 1'b0;
    stg_we = 1'b0; stg_re = 1'b0; stg_raddr = rc_q;
    slot_we = 1'b0; slot_re = 1'b0;
    slot_waddr = SAW'({idx_q, wj_q});
    slot_raddr = SAW'({di_q[2:0], dj_q});

    case (st_q)
      frr_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          ob_d = 8'd0;
          ov_d = 1'b0;
          ev_d = frr_pkg::EV_NONE;
          st_d = frr_pkg::ST_EMIT;
          case (cmd_i.kind)
            frr_pkg::FUNC_BYTE: begin
              if (cmd_i.frame_start) begin
                peer_d    = cmd_i.peer_match;
                rssi_feed = cmd_i.feed_rssi;
              end
              hdr_d = hdr_base;
              if (fbc_base < 8'd4) begin
                hdr_d = hdr_base | (32'(cmd_i.data_byte) << {fbc_base[1:0], 3'b000});
              end else begin
                stg_we = 1'b1;
              end
              fbc_d = (fbc_base <= frr_pkg::FRAME_LIMIT) ? fbc_base + 8'd1 : fbc_base;
              if (cmd_i.frame_end) begin
                st_d = frr_pkg::ST_CLASSIFY;
              end
            end
            frr_pkg::FUNC_TICK: begin
              time_d = time_q + 32'd1;
            end
            frr_pkg::FUNC_POP: begin
              if (head_q != tail_q) begin
                ring_re = 1'b1;
                st_d    = frr_pkg::ST_POP;
              end
            end
            default: ;
          endcase
        end
      end

      frr_pkg::ST_POP: begin
        ob_d   = ring_rdata;
        ov_d   = 1'b1;
        tail_d = tail_nxt;
        st_d   = frr_pkg::ST_EMIT;
      end

      frr_pkg::ST_CLASSIFY: begin
        fbc_d  = 8'd0;
        hdr_d  = 32'd0;
        peer_d = 1'b0;
        st_d   = frr_pkg::ST_EMIT;
        if (!peer_q || !cfg_i.link_paired) begin
          ev_d = frr_pkg::EV_IGNORED;
        end else if (fbc_q > frr_pkg::FRAME_LIMIT) begin
          ev_d = frr_pkg::EV_REJECTED;
        end else if (h_type == frr_pkg::TYPE_KEEPALIVE) begin
          if (fbc_q >= 8'd2) begin
            rssi_feed   = 1'b1;
            rssi_sample = $signed(h_seq);
          end
          ev_d = frr_pkg::EV_KEEPALIVE;
        end else if (h_type == frr_pkg::TYPE_REALTIME && fbc_q >= 8'd2) begin
          put_en   = 1'b1;
          put_data = h_seq;
          ev_d     = frr_pkg::EV_REALTIME;
        end else if (h_type == frr_pkg::TYPE_DATA && fbc_q >= 8'd4) begin
          if (frag_bad) begin
            ev_d = frr_pkg::EV_REJECTED;
          end else begin
            if (restart) begin
              got_d    = 8'd0;
              exp_d    = h_total[3:0];
              seq_d    = h_seq;
              pend_d   = 1'b1;
              tstart_d = time_q;
              clr_len  = 1'b1;
            end
            if (restart || exp_q == h_total[3:0]) begin
              idx_d  = h_idx[2:0];
              plen_d = h_plen;
              rc_d   = 8'd0;
              wv_d   = 1'b0;
              st_d   = frr_pkg::ST_COPY;
            end else begin
              ev_d = frr_pkg::EV_REJECTED;
            end
          end
        end else begin
          ev_d = frr_pkg::EV_IGNORED;
        end
      end

      // staging to slot, each byte is written in the cycle after its read
      frr_pkg::ST_COPY: begin
        wv_d = (rc_q < plen_q);
        wj_d = rc_q;
        if (rc_q < plen_q) begin
          stg_re = 1'b1;
          rc_d   = rc_q + 8'd1;
        end
        if (wv_q) begin
          slot_we = 1'b1;
        end
        if (rc_q == plen_q && !wv_q) begin
          len_we = 1'b1;
          got_d  = got_q | (8'd1 << idx_q);
          if ((got_d & total_mask) != total_mask) begin
            ev_d = frr_pkg::EV_STORED;
            st_d = frr_pkg::ST_EMIT;
          end else begin
            di_d = 4'd0;
            dj_d = 8'd0;
            st_d = frr_pkg::ST_DRAIN;
          end
        end
      end

      // walk the slots in order, pushing all but carriage returns, and add a line feed unless the last slot ends in one
      frr_pkg::ST_DRAIN: begin
        wv_d = 1'b0;
        if (di_q < exp_q) begin
          len_seen_d = cur_len;
          if (dj_q < cur_len) begin
            slot_re = 1'b1;
            wv_d    = 1'b1;
            if (9'(dj_q) + 9'd1 < 9'(cur_len)) begin
              dj_d = dj_q + 8'd1;
            end else begin
              di_d = di_q + 4'd1;
              dj_d = 8'd0;
            end
          end else begin
            di_d = di_q + 4'd1;
            dj_d = 8'd0;
          end
        end
        if (wv_q) begin
          lf_d = (slot_rdata == frr_pkg::CHAR_LF);
          if (slot_rdata != frr_pkg::CHAR_CR) begin
            put_en   = 1'b1;
            put_data = slot_rdata;
          end
        end
        if (di_q == exp_q && !wv_q) begin
          if (len_seen_q == 8'd0 || !lf_q) begin
            put_en   = 1'b1;
            put_data = frr_pkg::CHAR_LF;
          end
          pend_d = 1'b0;
          ev_d   = frr_pkg::EV_DELIVERED;
          st_d   = frr_pkg::ST_EMIT;
        end
      end

      frr_pkg::ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          st_d       = frr_pkg::ST_IDLE;
        end
      end

      default: st_d = frr_pkg::ST_IDLE;
    endcase

    if (rssi_feed) begin
      rssi_d = rssi_next(rssi_q, rssi_sample);
    end
    // a full ring drops the byte
    if (put_en && head_nxt != tail_q) begin
      ring_we = 1'b1;
      head_d  = head_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= frr_pkg::ST_IDLE;
      ev_q     <= frr_pkg::EV_NONE;
      head_q   <= '0;
      tail_q   <= '0;
      got_q    <= 8'd0;
      exp_q    <= 4'd0;
      seq_q    <= 8'd0;
      pend_q   <= 1'b0;
      tstart_q <= 32'd0;
      time_q   <= 32'd0;
      rssi_q   <= frr_pkg::RSSI_NONE;
      fbc_q    <= 8'd0;
      hdr_q    <= 32'd0;
      peer_q   <= 1'b0;
      ob_q     <= 8'd0;
      ov_q     <= 1'b0;
      rc_q     <= 8'd0;
      wv_q     <= 1'b0;
      di_q     <= 4'd0;
      dj_q     <= 8'd0;
      for (int k = 0; k < 8; k++) begin
        slot_len_q[k] <= 8'd0;
      end
    end else begin
      st_q     <= st_d;
      ev_q     <= ev_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      got_q    <= got_d;
      exp_q    <= exp_d;
      seq_q    <= seq_d;
      pend_q   <= pend_d;
      tstart_q <= tstart_d;
      time_q   <= time_d;
      rssi_q   <= rssi_d;
      fbc_q    <= fbc_d;
      hdr_q    <= hdr_d;
      peer_q   <= peer_d;
      ob_q     <= ob_d;
      ov_q     <= ov_d;
      rc_q     <= rc_d;
      wv_q     <= wv_d;
      di_q     <= di_d;
      dj_q     <= dj_d;
      if (clr_len) begin
        for (int k = 0; k < 8; k++) begin
          slot_len_q[k] <= 8'd0;
        end
      end else if (len_we) begin
        slot_len_q[idx_q] <= plen_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    plen_q     <= plen_d;
    wj_q       <= wj_d;
    len_seen_q <= len_seen_d;
    lf_q       <= lf_d;
  end

  frr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(head_q),
    .wdata_i(put_data),
    .re_i   (ring_re),
    .raddr_i(tail_q),
    .rdata_o(ring_rdata)
  );

  frr_ram #(.WIDTH(8), .DEPTH(256)) u_stage_ram (
    .clk_i  (clk_i),
    .we_i   (stg_we),
    .waddr_i(stg_waddr),
    .wdata_i(cmd_i.data_byte),
    .re_i   (stg_re),
    .raddr_i(stg_raddr),
    .rdata_o(stg_rdata)
  );

  frr_ram #(.WIDTH(8), .DEPTH(FRAG_SLOTS * 256)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(stg_rdata),
    .re_i   (slot_re),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  always_comb begin
    res_o.out_byte        = ob_q;
    res_o.out_valid       = ov_q;
    res_o.filtered_rssi   = rssi_q;
    res_o.bytes_waiting   = 11'(cnt_w);
    res_o.message_pending = pend_q;
    res_o.frame_event     = ev_q;
  end

  `FRR_ASSERT_IMPLY(a_ring_room, ring_we, head_nxt != tail_q, "ring written while full")
  `FRR_ASSERT_IMPLY(a_emit_room, res_push_o, !res_full_i, "result pushed into full queue")
  `FRR_ASSERT_IMPLY(a_got_range, pend_q, (got_q & ~total_mask) == 8'd0, "fragment beyond total")
  `FRR_ASSERT_IMPLY(a_idle_clean, st_q == frr_pkg::ST_IDLE, !wv_q, "slot write left in flight")

endmodule

`default_nettype wire
